// ===== hdl/uks_pkg.sv =====
// Shared types and codes of the unique key stack.
package uks_pkg;

  // Request operations. The fourth code is unused and is answered without any change.
  typedef enum logic [1:0] {
    OP_PUSH = 2'd0,
    OP_POP  = 2'd1,
    OP_PEEK = 2'd2
  } op_e;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_DUP   = 2'd1,
    ST_UNDER = 2'd2,
    ST_OVER  = 2'd3
  } status_e;

  localparam int unsigned WordW = 32;

  // One stored pair, as it moves between the sequencer and the store.
  typedef struct packed {
    logic signed [WordW-1:0] key;
    logic signed [WordW-1:0] value;
  } entry_t;

endpackage

// ===== hdl/uks_if.sv =====
// Request and response channel interfaces of the unique key stack.
interface uks_req_if;
  logic               valid;
  logic               ready;
  logic [1:0]         op;
  logic signed [31:0] key;
  logic signed [31:0] value;

  modport source (output valid, output op, output key, output value, input ready);
  modport sink   (input valid, input op, input key, input value, output ready);
endinterface

interface uks_rsp_if #(
  parameter int unsigned DepthW = 5
);
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic signed [31:0] out_key;
  logic signed [31:0] out_value;
  logic [DepthW-1:0]  depth_now;
  logic               is_empty;

  modport source (output valid, output status, output out_key, output out_value,
                  output depth_now, output is_empty, input ready);
  modport sink   (input valid, input status, input out_key, input out_value,
                  input depth_now, input is_empty, output ready);
endinterface

// ===== hdl/uks_store.sv =====
// Pair storage of the stack: one write port and one registered read port.
module uks_store import uks_pkg::*; #(
  parameter int unsigned Depth = 16,
  parameter int unsigned AddrW = 4
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  entry_t           wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output entry_t           rdata_o
);

  entry_t mem_q [Depth];
  entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/unique_key_stack_unit.sv =====
// Top level of the unique key stack: request sequencer, key scan and response register.
//
// A bounded LIFO of key and data pairs. Each request beat on req_i carries an op
// (push, pop or peek), a key and a data word; each request produces exactly one
// response beat on rsp_o with a status, the popped or peeked pair, the fill level
// after the request and an empty flag. A push is refused with a duplicate status
// when its key is already held anywhere in the stack, and with overflow when the
// stack is full; the duplicate check wins when both apply. Pop and peek on an
// empty stack report underflow. The unused op code leaves the stack untouched.
//
// A push scans the n stored keys through the single read port of the store and
// one shared comparator, one key per cycle, before its result is registered.
// Pop and peek wait for one registered read of the top pair. Underflow and the
// unused op finish in the cycle in which their request beat is taken.
//
// req_i.ready is high only while the sequencer is idle. A finished response sits
// in the output register until it is taken; while it waits, the next request can
// still be accepted, and its result is held until the register frees up.
// Reset empties the stack at once; the store itself is never cleared.
module unique_key_stack_unit import uks_pkg::*; #(
  parameter int unsigned STACK_DEPTH = 16,
  localparam int unsigned CntW  = $clog2(STACK_DEPTH + 1),
  localparam int unsigned AddrW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1
) (
  input  logic clk_i,
  input  logic rst_ni,
  uks_req_if.sink   req_i,
  uks_rsp_if.source rsp_o
);

  // Sequencer states.
  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_SCAN = 4'b0010,
    S_READ = 4'b0100,
    S_DONE = 4'b1000
  } state_e;

  state_e state_q, state_d;

  // Fill level, the scan issue pointer and the compare-pending flag.
  logic [CntW-1:0] count_q, count_d;
  logic [CntW-1:0] issue_q, issue_d;
  logic            cmp_vld_q, cmp_vld_d;

  // Latched request.
  logic [1:0]         op_q, op_d;
  logic signed [31:0] key_q, key_d;
  logic signed [31:0] val_q, val_d;

  // Result held while the output register is still occupied.
  status_e            res_status_q, res_status_d;
  logic signed [31:0] res_key_q, res_key_d;
  logic signed [31:0] res_val_q, res_val_d;

  // Output register.
  logic               out_valid_q, out_valid_d;
  status_e            out_status_q, out_status_d;
  logic signed [31:0] out_key_q, out_key_d;
  logic signed [31:0] out_val_q, out_val_d;
  logic [CntW-1:0]    out_depth_q, out_depth_d;

  // Store port.
  logic             mem_we, mem_re;
  logic [AddrW-1:0] mem_waddr, mem_raddr;
  entry_t           mem_wdata, mem_rdata;

  // Finish of the current request.
  logic               fin;
  status_e            fin_status;
  logic signed [31:0] fin_key, fin_val;
  logic               out_free, out_load, hit, full;
  logic [CntW-1:0]    top_idx;

  assign out_free = !out_valid_q || rsp_o.ready;
  assign full     = (count_q == CntW'(STACK_DEPTH));
  assign top_idx  = count_q - CntW'(1);
  // The store's read data belongs to the key issued in the previous cycle.
  assign hit      = cmp_vld_q && (mem_rdata.key == key_q);

  assign mem_waddr       = count_q[AddrW-1:0];
  assign mem_wdata.key   = key_q;
  assign mem_wdata.value = val_q;

  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    issue_d    = issue_q;
    cmp_vld_d  = 1'b0;
    op_d       = op_q;
    key_d      = key_q;
    val_d      = val_q;
    mem_we     = 1'b0;
    mem_re     = 1'b0;
    mem_raddr  = issue_q[AddrW-1:0];
    fin        = 1'b0;
    fin_status = ST_OK;
    fin_key    = '0;
    fin_val    = '0;

    unique case (state_q)
      S_IDLE: begin
        if (req_i.valid) begin
          op_d  = req_i.op;
          key_d = req_i.key;
          val_d = req_i.value;
          if (req_i.op == OP_PUSH) begin
            issue_d = '0;
            state_d = S_SCAN;
          end else if (req_i.op == OP_POP || req_i.op == OP_PEEK) begin
            if (count_q == '0) begin
              fin        = 1'b1;
              fin_status = ST_UNDER;
            end else begin
              mem_re    = 1'b1;
              mem_raddr = top_idx[AddrW-1:0];
              state_d   = S_READ;
            end
          end else begin
            fin = 1'b1;
          end
        end
      end
      S_SCAN: begin
        // Issue one stored key per cycle and compare it in the next cycle.
        mem_re    = (issue_q != count_q);
        cmp_vld_d = mem_re;
        if (mem_re) begin
          issue_d = issue_q + CntW'(1);
        end
        if (hit) begin
          fin        = 1'b1;
          fin_status = ST_DUP;
        end else if (!mem_re) begin
          // Every stored key has been issued and the last compare, if any, missed.
          fin = 1'b1;
          if (full) begin
            fin_status = ST_OVER;
          end else begin
            mem_we  = 1'b1;
            count_d = count_q + CntW'(1);
          end
        end
      end
      S_READ: begin
        fin     = 1'b1;
        fin_key = mem_rdata.key;
        fin_val = mem_rdata.value;
        if (op_q == OP_POP) begin
          count_d = top_idx;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (fin) begin
      state_d = out_free ? S_IDLE : S_DONE;
    end
  end

  // Park each finished result, for use when the output register is still occupied.
  always_comb begin
    res_status_d = res_status_q;
    res_key_d    = res_key_q;
    res_val_d    = res_val_q;
    if (fin) begin
      res_status_d = fin_status;
      res_key_d    = fin_key;
      res_val_d    = fin_val;
    end
  end

  assign out_load = (fin || state_q == S_DONE) && out_free;

  always_comb begin
    out_valid_d  = out_valid_q && !rsp_o.ready;
    out_status_d = out_status_q;
    out_key_d    = out_key_q;
    out_val_d    = out_val_q;
    out_depth_d  = out_depth_q;
    if (out_load) begin
      out_valid_d  = 1'b1;
      out_status_d = fin ? fin_status : res_status_q;
      out_key_d    = fin ? fin_key : res_key_q;
      out_val_d    = fin ? fin_val : res_val_q;
      out_depth_d  = count_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      cmp_vld_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      cmp_vld_q   <= cmp_vld_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    issue_q      <= issue_d;
    op_q         <= op_d;
    key_q        <= key_d;
    val_q        <= val_d;
    res_status_q <= res_status_d;
    res_key_q    <= res_key_d;
    res_val_q    <= res_val_d;
    out_status_q <= out_status_d;
    out_key_q    <= out_key_d;
    out_val_q    <= out_val_d;
    out_depth_q  <= out_depth_d;
  end

  uks_store #(
    .Depth (STACK_DEPTH),
    .AddrW (AddrW)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  assign req_i.ready     = (state_q == S_IDLE);
  assign rsp_o.valid     = out_valid_q;
  assign rsp_o.status    = out_status_q;
  assign rsp_o.out_key   = out_key_q;
  assign rsp_o.out_value = out_val_q;
  assign rsp_o.depth_now = out_depth_q;
  assign rsp_o.is_empty  = (out_depth_q == '0);

  // The fill level never passes the capacity.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(STACK_DEPTH))
    else $error("fill level above capacity");

  // A pair is only written while there is room for it.
  a_write_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> !full)
    else $error("store write on a full stack");

  // The scan never reads past the filled part of the store.
  a_scan_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN && mem_re) |-> (issue_q < count_q))
    else $error("scan read beyond fill level");

  // A held result is only dropped into the output register when it is free.
  a_done_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE && !out_free) |=> (state_q == S_DONE))
    else $error("held result left before the output register freed");

  // The fill level moves by at most one per cycle.
  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q != $past(count_q)) |->
      (count_q == $past(count_q) + CntW'(1) || count_q == $past(count_q) - CntW'(1)))
    else $error("fill level jumped");

endmodule

// ===== tb/sv/testbench.sv =====
// Self-checking testbench of the unique key stack: directed table, random traffic, scoreboard.
module testbench;
  import uks_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // The stack is built at its default depth; the fill level is five bits wide.
  localparam int unsigned StackDepth = 16;
  localparam int unsigned DepthW     = 5;

  // The fourth op code has no member in the package; it must leave the stack alone.
  localparam logic [1:0] OpUnused = 2'd3;

  localparam logic signed [31:0] KeyMin = 32'sh8000_0000;
  localparam logic signed [31:0] KeyMax = 32'sh7fff_ffff;

  localparam int DirectedCount = 26;
  localparam int RandomItems   = 800;

  // Pushes, sender gaps, receiver stalls and the long hold-off together take far
  // less than the budget below.
  localparam int CycleLimit  = 300_000;
  localparam int DrainCycles = 60;

  // One expected response beat.
  typedef struct {
    status_e            status;
    logic signed [31:0] pair_key;
    logic signed [31:0] pair_value;
    logic [DepthW-1:0]  depth;
    logic               empty_flag;
  } stack_result_t;

  // One row of the directed table. Rows with checked set carry their answer
  // typed in; the others are answered by the stack predictor.
  typedef struct {
    logic [1:0]         op;
    logic signed [31:0] key;
    logic signed [31:0] value;
    bit                 checked;
    stack_result_t      answer;
  } directed_row_t;

  localparam stack_result_t NoAnswer = '{ST_OK, 32'sd0, 32'sd0, 5'd0, 1'b0};

  // Receiver behaviors, each held for a random number of cycles.
  typedef enum {
    SinkOpen,
    SinkMostly,
    SinkSparse,
    SinkPeriodic
  } sink_mode_e;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  uks_req_if                     req ();
  uks_rsp_if #(.DepthW(DepthW)) rsp ();

  unique_key_stack_unit #(
    .STACK_DEPTH(StackDepth)
  ) uut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .req_i (req),
    .rsp_o (rsp)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Predicted contents of the stack. Entry i is meaningful for i < stack_fill.
  logic signed [31:0] stack_keys   [StackDepth];
  logic signed [31:0] stack_values [StackDepth];
  int unsigned        stack_fill;

  // Keys pushed lately. Drawing from them gives both duplicates (key still held)
  // and legal re-pushes (key popped meanwhile).
  logic signed [31:0] recent_keys [8];

  stack_result_t pending_results [$];
  int            mismatches    = 0;
  int            beats_checked = 0;
  int            burst_left    = 0;
  int            cycle_count   = 0;

  // Applies one request to the predicted stack and returns the response it earns.
  // The duplicate check comes before the capacity check, so a full stack still
  // answers a known key with the duplicate status.
  function automatic stack_result_t stack_apply(logic [1:0] op, logic signed [31:0] key,
                                                logic signed [31:0] value);
    stack_result_t r;
    bit            key_held;
    r.status     = ST_OK;
    r.pair_key   = '0;
    r.pair_value = '0;
    key_held     = 1'b0;
    case (op)
      OP_PUSH: begin
        for (int i = 0; i < stack_fill; i++) begin
          if (stack_keys[i] == key) key_held = 1'b1;
        end
        if (key_held) begin
          r.status = ST_DUP;
        end else if (stack_fill >= StackDepth) begin
          r.status = ST_OVER;
        end else begin
          stack_keys[stack_fill]   = key;
          stack_values[stack_fill] = value;
          stack_fill++;
        end
      end
      OP_POP, OP_PEEK: begin
        if (stack_fill == 0) begin
          r.status = ST_UNDER;
        end else begin
          r.pair_key   = stack_keys[stack_fill-1];
          r.pair_value = stack_values[stack_fill-1];
          if (op == OP_POP) stack_fill--;
        end
      end
      default: begin
        // The unused code only reports the current level.
      end
    endcase
    r.depth      = stack_fill[DepthW-1:0];
    r.empty_flag = (stack_fill == 0);
    return r;
  endfunction

  // Key choice for random pushes: held keys, recent keys, extremes, or any word.
  function automatic logic signed [31:0] pick_key();
    int                 sel;
    logic signed [31:0] k;
    sel = $urandom_range(0, 99);
    if (sel < 25 && stack_fill > 0) begin
      k = stack_keys[$urandom_range(0, stack_fill - 1)];
    end else if (sel < 45) begin
      k = recent_keys[$urandom_range(0, 7)];
    end else if (sel < 55) begin
      case ($urandom_range(0, 3))
        0:       k = KeyMin;
        1:       k = KeyMax;
        2:       k = '0;
        default: k = -32'sd1;
      endcase
    end else begin
      k = $urandom;
    end
    return k;
  endfunction

  // Offers one request beat and returns at the edge that accepts it. The sender
  // works in bursts; between bursts valid drops for a random number of cycles.
  task automatic send_request(logic [1:0] op, logic signed [31:0] key,
                              logic signed [31:0] value);
    if (burst_left == 0) begin
      req.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = $urandom_range(1, 30);
    end
    burst_left--;
    req.valid <= 1'b1;
    req.op    <= op;
    req.key   <= key;
    req.value <= value;
    do @(posedge clk); while (!req.ready);
  endtask

  // Compares one accepted response beat with the oldest expectation.
  task automatic check_result();
    stack_result_t want;
    if (pending_results.size() == 0) begin
      $error("response beat with nothing expected: status %0d key %0d value %0d",
             rsp.status, rsp.out_key, rsp.out_value);
      mismatches++;
    end else begin
      want = pending_results.pop_front();
      if (rsp.status !== want.status) begin
        $error("status: expected %0d, actual %0d", want.status, rsp.status);
        mismatches++;
      end
      if (rsp.out_key !== want.pair_key) begin
        $error("out_key: expected %0d, actual %0d", want.pair_key, rsp.out_key);
        mismatches++;
      end
      if (rsp.out_value !== want.pair_value) begin
        $error("out_value: expected %0d, actual %0d", want.pair_value, rsp.out_value);
        mismatches++;
      end
      if (rsp.depth_now !== want.depth) begin
        $error("depth_now: expected %0d, actual %0d", want.depth, rsp.depth_now);
        mismatches++;
      end
      if (rsp.is_empty !== want.empty_flag) begin
        $error("is_empty: expected %0d, actual %0d", want.empty_flag, rsp.is_empty);
        mismatches++;
      end
    end
    beats_checked++;
  endtask

  // Request side: reset, the directed table, then random traffic. Every accepted
  // beat is run through the predictor at the edge that accepts it, before its
  // response can possibly show up.
  initial begin : request_source
    directed_row_t      directed_rows [DirectedCount];
    stack_result_t      predicted;
    logic [1:0]         op;
    logic signed [31:0] key;
    logic signed [31:0] value;
    int                 push_weight;
    int                 phase_left;
    int                 sel;

    req.valid <= 1'b0;
    req.op    <= OP_PUSH;
    req.key   <= '0;
    req.value <= '0;
    stack_fill = 0;
    foreach (recent_keys[i]) recent_keys[i] = '0;

    directed_rows = '{
      // Reads and the unused code on an empty stack.
      '{OP_PEEK,  32'sd0,          32'sd0,          1'b1, '{ST_UNDER, 0, 0, 0, 1}},
      '{OP_POP,   32'sh0000_1234,  32'sh0000_5678,  1'b1, '{ST_UNDER, 0, 0, 0, 1}},
      '{OpUnused, KeyMax,          KeyMin,          1'b1, '{ST_OK, 0, 0, 0, 1}},
      // One pair of extremes in, read back, refused again, popped.
      '{OP_PUSH,  KeyMin,          KeyMax,          1'b1, '{ST_OK, 0, 0, 1, 0}},
      '{OP_PEEK,  32'sd0,          32'sd0,          1'b1, '{ST_OK, KeyMin, KeyMax, 1, 0}},
      '{OP_PUSH,  KeyMin,          32'sd0,          1'b1, '{ST_DUP, 0, 0, 1, 0}},
      '{OP_POP,   32'sd0,          32'sd0,          1'b1, '{ST_OK, KeyMin, KeyMax, 0, 1}},
      // Fill to capacity; the popped minimum key is legal again.
      '{OP_PUSH,  KeyMax,          KeyMin,          1'b0, NoAnswer},
      '{OP_PUSH,  KeyMin,          32'sd0,          1'b0, NoAnswer},
      '{OP_PUSH,  32'sd0,          -32'sd1,         1'b0, NoAnswer},
      '{OP_PUSH,  -32'sd1,         32'sd0,          1'b0, NoAnswer},
      '{OP_PUSH,  32'sd1,          KeyMax,          1'b0, NoAnswer},
      '{OP_PUSH,  32'sh5555_5555,  32'shaaaa_aaaa,  1'b0, NoAnswer},
      '{OP_PUSH,  32'shaaaa_aaaa,  32'sh5555_5555,  1'b0, NoAnswer},
      '{OP_PUSH,  32'sh0001_0000,  32'sh0000_ffff,  1'b0, NoAnswer},
      '{OP_PUSH,  32'sh7fff_fffe,  32'sh8000_0001,  1'b0, NoAnswer},
      '{OP_PUSH,  32'sh8000_0001,  32'sh7fff_fffe,  1'b0, NoAnswer},
      '{OP_PUSH,  32'sh0000_ffff,  32'shffff_0000,  1'b0, NoAnswer},
      '{OP_PUSH,  32'shffff_0000,  32'sh0000_ffff,  1'b0, NoAnswer},
      '{OP_PUSH,  32'sh1234_5678,  32'shdead_beef,  1'b0, NoAnswer},
      '{OP_PUSH,  32'shdead_beef,  32'sh1234_5678,  1'b0, NoAnswer},
      '{OP_PUSH,  32'sd2,          -32'sd2,         1'b0, NoAnswer},
      '{OP_PUSH,  -32'sd2,         32'sd2,          1'b0, NoAnswer},
      // Full stack: a new key overflows, a held key is still a duplicate.
      '{OP_PUSH,  32'sh0bad_f00d,  32'sd7,          1'b1, '{ST_OVER, 0, 0, 16, 0}},
      '{OP_PUSH,  KeyMax,          32'sd7,          1'b1, '{ST_DUP, 0, 0, 16, 0}},
      '{OpUnused, 32'sd0,          32'sd0,          1'b1, '{ST_OK, 0, 0, 16, 0}}
    };

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      send_request(directed_rows[i].op, directed_rows[i].key, directed_rows[i].value);
      predicted = stack_apply(directed_rows[i].op, directed_rows[i].key,
                              directed_rows[i].value);
      pending_results.push_back(directed_rows[i].checked ? directed_rows[i].answer
                                                         : predicted);
    end

    // Random traffic in phases that lean toward filling or toward draining, so
    // that overflow, underflow and duplicate refusals all come up often.
    push_weight = 50;
    phase_left  = 0;
    for (int n = 0; n < RandomItems; n++) begin
      // Halfway through, the sender stops until every response is back.
      if (n == RandomItems / 2) begin
        req.valid <= 1'b0;
        do @(posedge clk); while (pending_results.size() != 0);
      end
      if (phase_left == 0) begin
        case ($urandom_range(0, 2))
          0:       push_weight = 25;
          1:       push_weight = 55;
          default: push_weight = 85;
        endcase
        phase_left = $urandom_range(20, 60);
      end
      phase_left--;

      sel   = $urandom_range(0, 99);
      key   = $urandom;
      value = $urandom;
      if (sel < 3) begin
        op = OpUnused;
      end else if (sel < push_weight) begin
        op  = OP_PUSH;
        key = pick_key();
        recent_keys[$urandom_range(0, 7)] = key;
      end else begin
        op = ($urandom_range(0, 2) == 0) ? OP_PEEK : OP_POP;
      end

      send_request(op, key, value);
      pending_results.push_back(stack_apply(op, key, value));
    end
    req.valid <= 1'b0;

    // Drain, then give a stray extra beat time to appear.
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (mismatches == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

  // Response side: checks each accepted beat and drives ready from a pattern of
  // its own. Once, after a few hundred beats, ready stays low for a long
  // stretch while requests keep coming, so the held result and the request
  // in flight back up into the request channel.
  initial begin : response_sink
    sink_mode_e mode;
    int         mode_left;
    int         hold_left;
    int         tick;
    bit         held_once;
    rsp.ready <= 1'b0;
    mode      = SinkOpen;
    mode_left = 0;
    hold_left = 0;
    tick      = 0;
    held_once = 1'b0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (rsp.valid && rsp.ready) check_result();
      if (!held_once && beats_checked >= 300) begin
        held_once = 1'b1;
        hold_left = 300;
      end
      if (mode_left == 0) begin
        mode      = sink_mode_e'($urandom_range(0, 3));
        mode_left = $urandom_range(20, 200);
      end
      mode_left--;
      tick++;
      if (hold_left > 0) begin
        hold_left--;
        rsp.ready <= 1'b0;
      end else begin
        case (mode)
          SinkOpen:   rsp.ready <= 1'b1;
          SinkMostly: rsp.ready <= ($urandom_range(0, 3) != 0);
          SinkSparse: rsp.ready <= ($urandom_range(0, 3) == 0);
          default:    rsp.ready <= (tick % 5 == 0);
        endcase
      end
    end
  end

  // Watchdog on the whole run.
  initial begin : watchdog
    while (cycle_count < CycleLimit) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("testbench: FAIL");
    $finish;
  end

endmodule
